@@ design/cct_pkg.sv @@
package cct_pkg;

    typedef enum logic [0:0] {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    // highest unit that changed on an item
    typedef enum logic [2:0] {
        LVL_YEAR   = 3'd0,
        LVL_MONTH  = 3'd1,
        LVL_DAY    = 3'd2,
        LVL_HOUR   = 3'd3,
        LVL_MINUTE = 3'd4,
        LVL_SECOND = 3'd5,
        LVL_NONE   = 3'd6
    } level_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd2;

    typedef struct packed {
        logic [9:0] ticks_per_second;
        logic [7:0] scan_period;
        logic [9:0] blink_half_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ticks_per_second:  10'd1000,
        scan_period:       8'd10,
        blink_half_period: 10'd500
    };

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
    } cal_t;

    localparam cal_t CAL_RESET = '{
        year:        14'd2022,
        month:       4'd3,
        day:         5'd1,
        hour:        5'd20,
        minute:      6'd44,
        second:      6'd0,
        millisecond: 10'd0
    };

    typedef struct packed {
        func_t       func;
        logic [13:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } item_t;

    typedef struct packed {
        cal_t   cal;
        level_t level;
        logic   key_scan_strobe;
        logic   blink;
    } result_t;

    localparam logic [6:0] SEC_PER_MIN  = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;
    localparam logic [4:0] MONTH_END    = 5'd13;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ design/cct_if.sv @@
interface cct_tick_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;

    modport source (
        output valid, func, load_year, load_month, load_day, load_hour,
               load_minute, load_second,
        input  ready
    );
    modport sink (
        input  valid, func, load_year, load_month, load_day, load_hour,
               load_minute, load_second,
        output ready
    );
endinterface

interface cct_result_if;
    logic        valid;
    logic        ready;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [2:0]  rollover_level;
    logic        key_scan_strobe;
    logic        blink;

    modport source (
        output valid, year, month, day, hour, minute, second, millisecond,
               rollover_level, key_scan_strobe, blink,
        input  ready
    );
    modport sink (
        input  valid, year, month, day, hour, minute, second, millisecond,
               rollover_level, key_scan_strobe, blink,
        output ready
    );
endinterface

@@ design/cct_leap.sv @@
// Gregorian leap test. year/100 by reciprocal: (y * 5243) >> 19 is exact
// for every 14-bit y.
module cct_leap (
    input  logic [13:0] year,
    output logic        leap
);

    logic [26:0] prod;
    logic [7:0]  q100;
    logic        div100;
    logic        div400;

    always_comb
    begin
        prod   = 27'(year) * 27'd5243;
        q100   = prod[26:19];
        div100 = (year == 14'(14'(q100) * 14'd100));
        // divisible by 400 when divisible by 100 and the quotient by 4
        div400 = div100 && (q100[1:0] == 2'b00);
        leap   = (year[1:0] == 2'b00) && (!div100 || div400);
    end

endmodule

@@ design/cct_core.sv @@
module cct_core #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  cct_pkg::item_t  item,
    input  cct_pkg::cfg_t   cfg,
    output cct_pkg::result_t res
);

    cct_pkg::cal_t cal_reg, cal_next;
    logic [7:0]    scan_reg, scan_next;
    logic [9:0]    blink_cnt_reg, blink_cnt_next;
    logic          blink_reg, blink_next;

    logic          leap;
    logic [4:0]    mlen;
    logic [10:0]   ms_sum;
    logic [6:0]    sec_sum;
    logic [6:0]    min_sum;
    logic [5:0]    hour_sum;
    logic [5:0]    day_sum;
    logic [4:0]    month_sum;
    logic [14:0]   year_sum;
    logic [8:0]    scan_sum;
    logic [10:0]   blink_sum;
    cct_pkg::level_t level;
    logic          strobe;

    cct_leap u_leap (
        .year (cal_reg.year),
        .leap (leap)
    );

    always_comb
    begin
        mlen      = cct_pkg::month_len(cal_reg.month, leap);
        ms_sum    = {1'b0, cal_reg.millisecond} + 11'd1;
        sec_sum   = {1'b0, cal_reg.second} + 7'd1;
        min_sum   = {1'b0, cal_reg.minute} + 7'd1;
        hour_sum  = {1'b0, cal_reg.hour} + 6'd1;
        day_sum   = {1'b0, cal_reg.day} + 6'd1;
        month_sum = {1'b0, cal_reg.month} + 5'd1;
        year_sum  = {1'b0, cal_reg.year} + 15'd1;
        scan_sum  = {1'b0, scan_reg} + 9'd1;
        blink_sum = {1'b0, blink_cnt_reg} + 11'd1;

        cal_next       = cal_reg;
        scan_next      = scan_reg;
        blink_cnt_next = blink_cnt_reg;
        blink_next     = blink_reg;
        level          = cct_pkg::LVL_NONE;
        strobe         = 1'b0;

        if (item.func == cct_pkg::FUNC_LOAD)
        begin
            cal_next.year        = item.load_year;
            cal_next.month       = item.load_month;
            cal_next.day         = item.load_day;
            cal_next.hour        = item.load_hour;
            cal_next.minute      = item.load_minute;
            cal_next.second      = item.load_second;
            cal_next.millisecond = '0;
            level                = cct_pkg::LVL_YEAR;
        end
        else
        begin
            if (scan_sum >= {1'b0, cfg.scan_period})
            begin
                scan_next = '0;
                strobe    = 1'b1;
            end
            else
            begin
                scan_next = scan_sum[7:0];
            end

            if (blink_sum >= {1'b0, cfg.blink_half_period})
            begin
                blink_cnt_next = '0;
                blink_next     = ~blink_reg;
            end
            else
            begin
                blink_cnt_next = blink_sum[9:0];
            end

            // carry chain: each unit wraps only when every lower unit wrapped
            priority if (ms_sum < {1'b0, cfg.ticks_per_second})
            begin
                cal_next.millisecond = ms_sum[9:0];
                level                = cct_pkg::LVL_NONE;
            end
            else if (sec_sum < cct_pkg::SEC_PER_MIN)
            begin
                cal_next.millisecond = '0;
                cal_next.second      = sec_sum[5:0];
                level                = cct_pkg::LVL_SECOND;
            end
            else if (min_sum < cct_pkg::MIN_PER_HOUR)
            begin
                cal_next.millisecond = '0;
                cal_next.second      = '0;
                cal_next.minute      = min_sum[5:0];
                level                = cct_pkg::LVL_MINUTE;
            end
            else if (hour_sum < cct_pkg::HOUR_PER_DAY)
            begin
                cal_next.millisecond = '0;
                cal_next.second      = '0;
                cal_next.minute      = '0;
                cal_next.hour        = hour_sum[4:0];
                level                = cct_pkg::LVL_HOUR;
            end
            else if (day_sum <= {1'b0, mlen})
            begin
                cal_next.millisecond = '0;
                cal_next.second      = '0;
                cal_next.minute      = '0;
                cal_next.hour        = '0;
                cal_next.day         = day_sum[4:0];
                level                = cct_pkg::LVL_DAY;
            end
            else if (month_sum < cct_pkg::MONTH_END)
            begin
                cal_next.millisecond = '0;
                cal_next.second      = '0;
                cal_next.minute      = '0;
                cal_next.hour        = '0;
                cal_next.day         = 5'd1;
                cal_next.month       = month_sum[3:0];
                level                = cct_pkg::LVL_MONTH;
            end
            else
            begin
                cal_next.millisecond = '0;
                cal_next.second      = '0;
                cal_next.minute      = '0;
                cal_next.hour        = '0;
                cal_next.day         = 5'd1;
                cal_next.month       = 4'd1;
                cal_next.year        = (year_sum > 15'(YEAR_LIMIT)) ? 14'd0 : year_sum[13:0];
                level                = cct_pkg::LVL_YEAR;
            end
        end

        res.cal             = cal_next;
        res.level           = level;
        res.key_scan_strobe = strobe;
        res.blink           = blink_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg       <= cct_pkg::CAL_RESET;
            scan_reg      <= '0;
            blink_cnt_reg <= '0;
            blink_reg     <= 1'b0;
        end
        else if (en)
        begin
            cal_reg       <= cal_next;
            scan_reg      <= scan_next;
            blink_cnt_reg <= blink_cnt_next;
            blink_reg     <= blink_next;
        end
    end

endmodule

@@ design/calendar_clock_tick.sv @@
// Millisecond real time clock with Gregorian calendar.
// tick channel: one item per millisecond tick (func = 0) or a calendar load
// (func = 1, load_* fields stored as given, millisecond cleared).
// result channel: one item per accepted item with the full time after it,
// the highest unit that changed, the key scan strobe and the blink flag.
// cfg_we/cfg_index/cfg_data write ticks_per_second (0), scan_period (1) and
// blink_half_period (2); write only while no item is in flight.
// An item passes through the input register, then the result register,
// before its result is valid. Throughput: one item per cycle while the
// receiver takes results; the whole carry chain and leap test sit in one
// register-to-register step.
// Reset: time 20:44:00.000 on day 1 of month 3, year 2022; scan and blink
// counters cleared, blink low, registers at 1000/10/500.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; tick.ready drops once both are full.
module calendar_clock_tick #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cct_tick_if.sink                      tick,
    cct_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [cct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0] cfg_data
);

    cct_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg, in_valid_next;
    cct_pkg::item_t   in_item_reg;
    logic             out_valid_reg, out_valid_next;
    cct_pkg::result_t out_reg;
    cct_pkg::result_t core_res;
    cct_pkg::item_t   tick_item;
    logic             advance;
    logic             take;

    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || result.ready);
        tick.ready     = !in_valid_reg || advance;
        take           = tick.valid && tick.ready;
        in_valid_next  = take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !result.ready);

        tick_item.func        = cct_pkg::func_t'(tick.func);
        tick_item.load_year   = tick.load_year;
        tick_item.load_month  = tick.load_month;
        tick_item.load_day    = tick.load_day;
        tick_item.load_hour   = tick.load_hour;
        tick_item.load_minute = tick.load_minute;
        tick_item.load_second = tick.load_second;
    end

    cct_core #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cct_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cct_pkg::CFG_TICKS: cfg_reg.ticks_per_second  <= cfg_data;
                cct_pkg::CFG_SCAN:  cfg_reg.scan_period       <= cfg_data[7:0];
                cct_pkg::CFG_BLINK: cfg_reg.blink_half_period <= cfg_data;
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= tick_item;
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.year            = out_reg.cal.year;
    assign result.month           = out_reg.cal.month;
    assign result.day             = out_reg.cal.day;
    assign result.hour            = out_reg.cal.hour;
    assign result.minute          = out_reg.cal.minute;
    assign result.second          = out_reg.cal.second;
    assign result.millisecond     = out_reg.cal.millisecond;
    assign result.rollover_level  = out_reg.level;
    assign result.key_scan_strobe = out_reg.key_scan_strobe;
    assign result.blink           = out_reg.blink;

    // input stage only blocks when it holds an item
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> in_valid_reg)
        else $error("tick.ready low with empty input stage");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item did not reach result stage");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.func == cct_pkg::FUNC_LOAD) |=>
            (out_reg.cal.millisecond == '0) && (out_reg.level == cct_pkg::LVL_YEAR)
            && !out_reg.key_scan_strobe)
        else $error("load item gave wrong result");

    // any carry out of the tick counter leaves it at zero
    a_level_ms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_reg.level == cct_pkg::LVL_NONE) == (out_reg.cal.millisecond != '0)))
        else $error("rollover level disagrees with millisecond count");

endmodule
